[src/fcgirp_pkg.sv]
// Shared types and constants for the FastCGI record parser.
`timescale 1ns / 1ps

package fcgirp_pkg;

  // Result item codes
  typedef enum logic [2:0] {
    EV_HEADER    = 3'd0,
    EV_BEGIN     = 3'd1,
    EV_LENGTHS   = 3'd2,
    EV_BYTE      = 3'd3,
    EV_UNKNOWN   = 3'd4,
    EV_BADVER    = 3'd5,
    EV_MALFORMED = 3'd6,
    EV_END       = 3'd7
  } fcgirp_event_t;

  // Record types handled by the parser
  localparam logic [7:0] REC_BEGIN  = 8'd1;
  localparam logic [7:0] REC_ABORT  = 8'd2;
  localparam logic [7:0] REC_PARAMS = 8'd4;
  localparam logic [7:0] REC_STDIN  = 8'd5;

  localparam logic [7:0] FCGI_VERSION = 8'd1;
  localparam logic [7:0] LEN_TOP      = 8'h7F;

  typedef struct packed {
    fcgirp_event_t event_res;
    logic [7:0]    record_type;
    logic [15:0]   request_id;
    logic [15:0]   content_length;
    logic [7:0]    padding_length;
    logic [15:0]   role;
    logic          keep_connection;
    logic [30:0]   name_length;
    logic [30:0]   value_length;
    logic [7:0]    payload_byte;
    logic          record_end;
  } fcgirp_res_t;

endpackage

[src/fcgirp_core.sv]
// Parser state and per-byte decode: header, content, padding and params pairs.
`timescale 1ns / 1ps

module fcgirp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          stream_byte,
  output logic                res_valid,
  output fcgirp_pkg::fcgirp_res_t res
);
  import fcgirp_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_CONTENT,
    PH_PADDING
  } phase_t;

  typedef enum logic [2:0] {
    PP_NLEN,
    PP_NMORE,
    PP_VLEN,
    PP_VMORE,
    PP_NAME,
    PP_VALUE,
    PP_SKIP
  } pair_phase_t;

  phase_t      phase_r, phase_nxt;
  pair_phase_t pp_r, pp_nxt;
  logic [2:0]  hc_r, hc_nxt;
  logic [47:0] hf_r, hf_nxt;
  logic [15:0] cl_r, cl_nxt;
  logic [7:0]  pl_r, pl_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic [30:0] pbl_r, pbl_nxt;
  logic [23:0] bb_r, bb_nxt;
  logic [1:0]  lb_r, lb_nxt;
  logic        aborted_r, aborted_nxt;

  fcgirp_event_t ev;
  logic        has_ev, end_f, blank, last, done;
  logic [15:0] pos;
  logic [15:0] role;
  logic        keep;
  logic [30:0] nl, vl;
  logic [7:0]  pb;
  logic [31:0] need;
  logic [7:0]  b;

  assign b = stream_byte;

  always_comb begin
    phase_nxt   = phase_r;
    pp_nxt      = pp_r;
    hc_nxt      = hc_r;
    hf_nxt      = hf_r;
    cl_nxt      = cl_r;
    pl_nxt      = pl_r;
    acc_nxt     = acc_r;
    pbl_nxt     = pbl_r;
    bb_nxt      = bb_r;
    lb_nxt      = lb_r;
    aborted_nxt = aborted_r;
    ev     = EV_END;
    has_ev = 1'b0;
    end_f  = 1'b0;
    blank  = 1'b0;
    last   = 1'b0;
    done   = 1'b0;
    pos    = '0;
    role   = '0;
    keep   = 1'b0;
    nl     = '0;
    vl     = '0;
    pb     = '0;
    need   = '0;

    if (step && !aborted_r) begin
      case (phase_r)
        PH_HEADER: begin
          if (hc_r == 3'd0) begin
            if (b != FCGI_VERSION) begin
              aborted_nxt = 1'b1;
              has_ev      = 1'b1;
              ev          = EV_BADVER;
              pb          = b;
              blank       = 1'b1;
            end else begin
              hf_nxt = '0;
              hc_nxt = 3'd1;
            end
          end else begin
            case (hc_r)
              3'd1: hf_nxt[47:40] = b;
              3'd2: hf_nxt[39:32] = b;
              3'd3: hf_nxt[31:24] = b;
              3'd4: hf_nxt[23:16] = b;
              3'd5: hf_nxt[15:8]  = b;
              3'd6: hf_nxt[7:0]   = b;
              default: ;
            endcase
            if (hc_r == 3'd7) begin
              hc_nxt  = 3'd0;
              cl_nxt  = hf_r[23:8];
              pl_nxt  = hf_r[7:0];
              pp_nxt  = PP_NLEN;
              acc_nxt = '0;
              pbl_nxt = '0;
              lb_nxt  = '0;
              bb_nxt  = '0;
              has_ev  = 1'b1;
              ev = (hf_r[47:40] inside {REC_BEGIN, REC_ABORT, REC_PARAMS, REC_STDIN}) ?
                   EV_HEADER : EV_UNKNOWN;
              if (hf_r[23:8] != 16'd0) begin
                phase_nxt = PH_CONTENT;
              end else if (hf_r[7:0] != 8'd0) begin
                phase_nxt = PH_PADDING;
              end else begin
                end_f = 1'b1;
              end
            end else begin
              hc_nxt = hc_r + 3'd1;
            end
          end
        end

        PH_CONTENT: begin
          pos    = hf_r[23:8] - cl_r;
          cl_nxt = cl_r - 16'd1;
          last   = (cl_nxt == 16'd0);

          if (hf_r[47:40] == REC_BEGIN) begin
            if (pos < 16'd3) begin
              case (pos[1:0])
                2'd0:    bb_nxt[23:16] = b;
                2'd1:    bb_nxt[15:8]  = b;
                default: bb_nxt[7:0]   = b;
              endcase
              if (pos == 16'd2) begin
                has_ev = 1'b1;
                ev     = EV_BEGIN;
                role   = bb_r[23:8];
                keep   = b[0];
              end else if (last) begin
                has_ev = 1'b1;
                ev     = EV_MALFORMED;
              end
            end
          end else if (hf_r[47:40] == REC_STDIN) begin
            has_ev = 1'b1;
            ev     = EV_BYTE;
            pb     = b;
          end else if (hf_r[47:40] == REC_PARAMS) begin
            case (pp_r)
              PP_NLEN: begin
                if (b[7]) begin
                  acc_nxt = {23'd0, b & LEN_TOP};
                  lb_nxt  = 2'd3;
                  pp_nxt  = PP_NMORE;
                end else begin
                  pbl_nxt = {23'd0, b};
                  pp_nxt  = PP_VLEN;
                end
              end
              PP_NMORE: begin
                acc_nxt = {acc_r[22:0], b};
                lb_nxt  = lb_r - 2'd1;
                if (lb_nxt == 2'd0) begin
                  pbl_nxt = acc_nxt;
                  pp_nxt  = PP_VLEN;
                end
              end
              PP_VLEN: begin
                if (b[7]) begin
                  acc_nxt = {23'd0, b & LEN_TOP};
                  lb_nxt  = 2'd3;
                  pp_nxt  = PP_VMORE;
                end else begin
                  acc_nxt = {23'd0, b};
                  done    = 1'b1;
                end
              end
              PP_VMORE: begin
                acc_nxt = {acc_r[22:0], b};
                lb_nxt  = lb_r - 2'd1;
                if (lb_nxt == 2'd0) begin
                  done = 1'b1;
                end
              end
              PP_NAME: begin
                has_ev  = 1'b1;
                ev      = EV_BYTE;
                pb      = b;
                pbl_nxt = pbl_r - 31'd1;
                if (pbl_nxt == 31'd0) begin
                  if (acc_r != 31'd0) begin
                    pbl_nxt = acc_r;
                    pp_nxt  = PP_VALUE;
                  end else begin
                    pp_nxt = PP_NLEN;
                  end
                end
              end
              PP_VALUE: begin
                has_ev  = 1'b1;
                ev      = EV_BYTE;
                pb      = b;
                pbl_nxt = pbl_r - 31'd1;
                if (pbl_nxt == 31'd0) begin
                  pp_nxt = PP_NLEN;
                end
              end
              default: ;
            endcase

            if (done) begin
              need   = {1'b0, pbl_nxt} + {1'b0, acc_nxt};
              nl     = pbl_nxt;
              vl     = acc_nxt;
              has_ev = 1'b1;
              if (need > {16'd0, cl_nxt}) begin
                ev     = EV_MALFORMED;
                pp_nxt = PP_SKIP;
              end else begin
                ev = EV_LENGTHS;
                if (pbl_nxt != 31'd0) begin
                  pp_nxt = PP_NAME;
                end else if (acc_nxt != 31'd0) begin
                  pbl_nxt = acc_nxt;
                  pp_nxt  = PP_VALUE;
                end else begin
                  pp_nxt = PP_NLEN;
                end
              end
            end

            // Content ran out in the middle of a length field
            if (last && !has_ev &&
                (pp_nxt == PP_NMORE || pp_nxt == PP_VLEN || pp_nxt == PP_VMORE)) begin
              has_ev = 1'b1;
              ev     = EV_MALFORMED;
            end
          end

          if (last) begin
            if (pl_r != 8'd0) begin
              phase_nxt = PH_PADDING;
            end else begin
              phase_nxt = PH_HEADER;
              end_f     = 1'b1;
            end
          end
        end

        PH_PADDING: begin
          pl_nxt = pl_r - 8'd1;
          if (pl_nxt == 8'd0) begin
            phase_nxt = PH_HEADER;
            end_f     = 1'b1;
          end
        end

        default: phase_nxt = PH_HEADER;
      endcase

      if (end_f && !has_ev) begin
        has_ev = 1'b1;
        ev     = EV_END;
      end
    end
  end

  assign res_valid = has_ev;

  always_comb begin
    res.event_res       = ev;
    res.record_type     = blank ? 8'd0  : hf_r[47:40];
    res.request_id      = blank ? 16'd0 : hf_r[39:24];
    res.content_length  = blank ? 16'd0 : hf_r[23:8];
    res.padding_length  = blank ? 8'd0  : hf_r[7:0];
    res.role            = role;
    res.keep_connection = keep;
    res.name_length     = nl;
    res.value_length    = vl;
    res.payload_byte    = pb;
    res.record_end      = end_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      pp_r      <= PP_NLEN;
      hc_r      <= '0;
      hf_r      <= '0;
      cl_r      <= '0;
      pl_r      <= '0;
      acc_r     <= '0;
      pbl_r     <= '0;
      bb_r      <= '0;
      lb_r      <= '0;
      aborted_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      pp_r      <= pp_nxt;
      hc_r      <= hc_nxt;
      hf_r      <= hf_nxt;
      cl_r      <= cl_nxt;
      pl_r      <= pl_nxt;
      acc_r     <= acc_nxt;
      pbl_r     <= pbl_nxt;
      bb_r      <= bb_nxt;
      lb_r      <= lb_nxt;
      aborted_r <= aborted_nxt;
    end
  end

  // Abort lasts until reset
  a_abort_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    aborted_r |=> aborted_r)
    else $error("abort flag cleared without reset");

  // Header byte count only advances during the header phase
  a_hc_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (hc_r != 3'd0) |-> (phase_r == PH_HEADER))
    else $error("header count nonzero outside header phase");

  // Remaining length bytes only while a 4-byte length is being gathered
  a_lb_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (lb_r != 2'd0) |-> (pp_r == PP_NMORE || pp_r == PP_VMORE))
    else $error("length byte count outside a long length field");

endmodule

[src/fcgirp_skid.sv]
// Result register with skid stage between the parser and the result channel.
`timescale 1ns / 1ps

module fcgirp_skid (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push_valid,
  input  fcgirp_pkg::fcgirp_res_t     push_data,
  output logic                        push_stall,
  output logic                        out_valid,
  output fcgirp_pkg::fcgirp_res_t     out_data,
  input  logic                        out_stall
);
  import fcgirp_pkg::*;

  logic        main_valid_r, main_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  fcgirp_res_t main_r, main_nxt;
  fcgirp_res_t skid_r, skid_nxt;
  logic        pop;

  assign pop = main_valid_r && !out_stall;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_valid_nxt = 1'b1;
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = push_valid;
        main_nxt       = push_data;
      end
    end else if (push_valid && !skid_valid_r) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign push_stall = skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_data   = main_r;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held while result register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (main_valid_r && out_stall && !skid_valid_r && push_valid) |=> skid_valid_r)
    else $error("result lost while output stalled");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> !skid_valid_r)
    else $error("skid entry not drained on pop");

endmodule

[src/fastcgi_record_parser.sv]
// Top level of the FastCGI record parser: byte input channel, result item channel.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_stream_byte) takes one byte of the
//    connection stream per item. An item is taken on a clock edge where in_valid
//    is high and in_stall is low.
//  - Result channel (out_valid / out_stall / out_*) gives at most one result item
//    per input byte, in stream order. Bytes 0..6 of a good header, padding bytes
//    before the last one and skipped content give no result.
//  - Results are registered: out_* is driven by the result register, not by the decode.
//  - Throughput: one byte per cycle while in_stall is low; the decode for a byte fits
//    between the parser state registers and the result register.
//  - in_stall is registered: it rises only when the result register and the
//    skid entry are both occupied, i.e. after the receiver holds out_stall.
//    Taking bytes resumes the cycle after the skid entry drains.
//  - Reset (rst_n low, synchronous) drops any held result and returns the parser
//    to the start of a record header with the abort flag clear.
//  - A bad version byte gives one result and then every further byte is dropped
//    until reset.
`timescale 1ns / 1ps

module fastcgi_record_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_record_type,
  output logic [15:0] out_request_id,
  output logic [15:0] out_content_length,
  output logic [7:0]  out_padding_length,
  output logic [15:0] out_role,
  output logic        out_keep_connection,
  output logic [30:0] out_name_length,
  output logic [30:0] out_value_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_record_end
);
  import fcgirp_pkg::*;

  logic        in_accept;
  logic        core_valid;
  fcgirp_res_t core_res;
  fcgirp_res_t out_res;
  logic        skid_full;

  // Advance the parser only on an accepted byte
  assign in_accept = in_valid && !skid_full;
  assign in_stall  = skid_full;

  fcgirp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_accept),
    .stream_byte (in_stream_byte),
    .res_valid   (core_valid),
    .res         (core_res)
  );

  // Hold results here while the receiver stalls
  fcgirp_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (core_valid),
    .push_data  (core_res),
    .push_stall (skid_full),
    .out_valid  (out_valid),
    .out_data   (out_res),
    .out_stall  (out_stall)
  );

  // Unpack the result item onto its field ports
  assign out_event_res       = out_res.event_res;
  assign out_record_type     = out_res.record_type;
  assign out_request_id      = out_res.request_id;
  assign out_content_length  = out_res.content_length;
  assign out_padding_length  = out_res.padding_length;
  assign out_role            = out_res.role;
  assign out_keep_connection = out_res.keep_connection;
  assign out_name_length     = out_res.name_length;
  assign out_value_length    = out_res.value_length;
  assign out_payload_byte    = out_res.payload_byte;
  assign out_record_end      = out_res.record_end;

endmodule

[verif/fcgirp_scoreboard.sv]
// Record parser scoreboard: parser state mirror and queue of expected result items.
`timescale 1ns / 1ps

package fcgirp_tb_pkg;
  import fcgirp_pkg::*;

  typedef enum logic [1:0] {PH_HDR, PH_BODY, PH_PAD} parse_phase_t;
  typedef enum logic [2:0] {
    PS_NLEN, PS_NMORE, PS_VLEN, PS_VMORE, PS_NAME, PS_VALUE, PS_SKIP
  } pair_state_t;

  class record_scoreboard;
    fcgirp_res_t  want_q[$];
    int unsigned  mismatches;
    int unsigned  results_seen;

    parse_phase_t phase;
    logic [2:0]   hdr_cnt;
    logic [47:0]  hdr;
    logic [15:0]  body_left;
    logic [7:0]   pad_left;
    pair_state_t  pair_st;
    logic [30:0]  len_acc;
    logic [31:0]  pair_left;
    logic [23:0]  begin_bits;
    logic [1:0]   len_more;
    bit           dead;

    function new();
      mismatches   = 0;
      results_seen = 0;
      phase        = PH_HDR;
      hdr_cnt      = '0;
      hdr          = '0;
      body_left    = '0;
      pad_left     = '0;
      pair_st      = PS_NLEN;
      len_acc      = '0;
      pair_left    = '0;
      begin_bits   = '0;
      len_more     = '0;
      dead         = 1'b0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    // Advance the parser mirror by one stream byte; queue the result item it causes, if any.
    function void note_byte(logic [7:0] b);
      fcgirp_res_t r;
      bit          hit, fin, blank, last, done;
      int          pos, idx;
      logic [7:0]  rtype;
      logic [32:0] need;
      r     = '0;
      hit   = 1'b0;
      fin   = 1'b0;
      blank = 1'b0;
      last  = 1'b0;
      done  = 1'b0;
      if (dead) return;
      rtype = hdr[47:40];
      case (phase)
        PH_HDR: begin
          if (hdr_cnt == 0) begin
            if (b != FCGI_VERSION) begin
              dead           = 1'b1;
              hit            = 1'b1;
              blank          = 1'b1;
              r.event_res    = EV_BADVER;
              r.payload_byte = b;
            end else begin
              hdr     = '0;
              hdr_cnt = 3'd1;
            end
          end else begin
            if (hdr_cnt <= 6) begin
              idx = 8 * (6 - int'(hdr_cnt));
              hdr[idx +: 8] = b;
            end
            if (hdr_cnt == 7) begin
              hdr_cnt    = '0;
              body_left  = hdr[23:8];
              pad_left   = hdr[7:0];
              pair_st    = PS_NLEN;
              len_acc    = '0;
              pair_left  = '0;
              len_more   = '0;
              begin_bits = '0;
              hit        = 1'b1;
              rtype      = hdr[47:40];
              r.event_res = (rtype == REC_BEGIN || rtype == REC_ABORT ||
                             rtype == REC_PARAMS || rtype == REC_STDIN) ? EV_HEADER : EV_UNKNOWN;
              if (body_left != 0) phase = PH_BODY;
              else if (pad_left != 0) phase = PH_PAD;
              else fin = 1'b1;
            end else begin
              hdr_cnt = hdr_cnt + 3'd1;
            end
          end
        end
        PH_BODY: begin
          pos       = int'(hdr[23:8] - body_left);
          body_left = body_left - 16'd1;
          last      = (body_left == 0);
          if (rtype == REC_BEGIN) begin
            if (pos < 3) begin
              begin_bits[8 * (2 - pos) +: 8] = b;
              if (pos == 2) begin
                hit               = 1'b1;
                r.event_res       = EV_BEGIN;
                r.role            = begin_bits[23:8];
                r.keep_connection = begin_bits[0];
              end else if (last) begin
                hit         = 1'b1;
                r.event_res = EV_MALFORMED;
              end
            end
          end else if (rtype == REC_STDIN) begin
            hit            = 1'b1;
            r.event_res    = EV_BYTE;
            r.payload_byte = b;
          end else if (rtype == REC_PARAMS) begin
            case (pair_st)
              PS_NLEN: begin
                if (b[7]) begin
                  len_acc  = {24'd0, b[6:0]};
                  len_more = 2'd3;
                  pair_st  = PS_NMORE;
                end else begin
                  pair_left = {24'd0, b};
                  pair_st   = PS_VLEN;
                end
              end
              PS_NMORE: begin
                len_acc  = {len_acc[22:0], b};
                len_more = len_more - 2'd1;
                if (len_more == 0) begin
                  pair_left = {1'b0, len_acc};
                  pair_st   = PS_VLEN;
                end
              end
              PS_VLEN: begin
                if (b[7]) begin
                  len_acc  = {24'd0, b[6:0]};
                  len_more = 2'd3;
                  pair_st  = PS_VMORE;
                end else begin
                  len_acc = {23'd0, b};
                  done    = 1'b1;
                end
              end
              PS_VMORE: begin
                len_acc  = {len_acc[22:0], b};
                len_more = len_more - 2'd1;
                if (len_more == 0) done = 1'b1;
              end
              PS_NAME: begin
                hit            = 1'b1;
                r.event_res    = EV_BYTE;
                r.payload_byte = b;
                pair_left      = pair_left - 32'd1;
                if (pair_left == 0) begin
                  if (len_acc != 0) begin
                    pair_left = {1'b0, len_acc};
                    pair_st   = PS_VALUE;
                  end else begin
                    pair_st = PS_NLEN;
                  end
                end
              end
              PS_VALUE: begin
                hit            = 1'b1;
                r.event_res    = EV_BYTE;
                r.payload_byte = b;
                pair_left      = pair_left - 32'd1;
                if (pair_left == 0) pair_st = PS_NLEN;
              end
              default: ;
            endcase
            if (done) begin
              need           = {1'b0, pair_left} + {2'b00, len_acc};
              hit            = 1'b1;
              r.name_length  = pair_left[30:0];
              r.value_length = len_acc;
              if (need > {17'd0, body_left}) begin
                r.event_res = EV_MALFORMED;
                pair_st     = PS_SKIP;
              end else begin
                r.event_res = EV_LENGTHS;
                if (pair_left != 0) begin
                  pair_st = PS_NAME;
                end else if (len_acc != 0) begin
                  pair_left = {1'b0, len_acc};
                  pair_st   = PS_VALUE;
                end else begin
                  pair_st = PS_NLEN;
                end
              end
            end
            // content ran out in the middle of a length field
            if (last && !hit &&
                (pair_st == PS_NMORE || pair_st == PS_VLEN || pair_st == PS_VMORE)) begin
              hit         = 1'b1;
              r.event_res = EV_MALFORMED;
            end
          end
          if (last) begin
            if (pad_left != 0) begin
              phase = PH_PAD;
            end else begin
              phase = PH_HDR;
              fin   = 1'b1;
            end
          end
        end
        default: begin
          pad_left = pad_left - 8'd1;
          if (pad_left == 0) begin
            phase = PH_HDR;
            fin   = 1'b1;
          end
        end
      endcase
      if (fin && !hit) begin
        hit         = 1'b1;
        r.event_res = EV_END;
      end
      if (!hit) return;
      if (!blank) begin
        r.record_type    = hdr[47:40];
        r.request_id     = hdr[39:24];
        r.content_length = hdr[23:8];
        r.padding_length = hdr[7:0];
      end
      r.record_end = fin;
      want_q.push_back(r);
    endfunction

    function string show(fcgirp_res_t r);
      return $sformatf({"ev=%0d type=%02h id=%04h clen=%04h pad=%02h role=%04h keep=%0b ",
                        "nlen=%0h vlen=%0h byte=%02h end=%0b"},
                       r.event_res, r.record_type, r.request_id, r.content_length,
                       r.padding_length, r.role, r.keep_connection, r.name_length,
                       r.value_length, r.payload_byte, r.record_end);
    endfunction

    // Compare one accepted result item with the oldest expectation.
    function void check_result(fcgirp_res_t got);
      fcgirp_res_t want;
      string       diffs;
      results_seen++;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d with nothing expected: %s",
                                       results_seen, show(got));
        return;
      end
      want  = want_q.pop_front();
      diffs = "";
      if (got.event_res       !== want.event_res)       diffs = {diffs, " event_res"};
      if (got.record_type     !== want.record_type)     diffs = {diffs, " record_type"};
      if (got.request_id      !== want.request_id)      diffs = {diffs, " request_id"};
      if (got.content_length  !== want.content_length)  diffs = {diffs, " content_length"};
      if (got.padding_length  !== want.padding_length)  diffs = {diffs, " padding_length"};
      if (got.role            !== want.role)            diffs = {diffs, " role"};
      if (got.keep_connection !== want.keep_connection) diffs = {diffs, " keep_connection"};
      if (got.name_length     !== want.name_length)     diffs = {diffs, " name_length"};
      if (got.value_length    !== want.value_length)    diffs = {diffs, " value_length"};
      if (got.payload_byte    !== want.payload_byte)    diffs = {diffs, " payload_byte"};
      if (got.record_end      !== want.record_end)      diffs = {diffs, " record_end"};
      if (diffs != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d differs in%s", results_seen, diffs);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

endpackage

[verif/tb_top.sv]
// Testbench top for the FastCGI record parser: stimulus, handshakes and final verdict.
`timescale 1ns / 1ps

module tb_top;
  import fcgirp_pkg::*;
  import fcgirp_tb_pkg::*;

  // Cycles with no item moving on either channel before the run is called hung.
  // Longest legal quiet stretch is a long sender gap or receiver stall from pause_len().
  localparam int IDLE_LIMIT   = 5000;
  localparam int RANDOM_BYTES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_stream_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_res;
  logic [7:0]  out_record_type;
  logic [15:0] out_request_id;
  logic [15:0] out_content_length;
  logic [7:0]  out_padding_length;
  logic [15:0] out_role;
  logic        out_keep_connection;
  logic [30:0] out_name_length;
  logic [30:0] out_value_length;
  logic [7:0]  out_payload_byte;
  logic        out_record_end;

  record_scoreboard sb = new();

  bit          calm;          // when set, neither side idles
  int unsigned idle_cycles;
  int unsigned sent_bytes;
  int unsigned stall_hold;
  logic [7:0]  rec_body[$];   // content of the record being built

  fastcgi_record_parser dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_stream_byte      (in_stream_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_event_res       (out_event_res),
    .out_record_type     (out_record_type),
    .out_request_id      (out_request_id),
    .out_content_length  (out_content_length),
    .out_padding_length  (out_padding_length),
    .out_role            (out_role),
    .out_keep_connection (out_keep_connection),
    .out_name_length     (out_name_length),
    .out_value_length    (out_value_length),
    .out_payload_byte    (out_payload_byte),
    .out_record_end      (out_record_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length shared by both sides: mostly short, now and then a long one.
  function automatic int unsigned pause_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Receiver: alternate random stretches of taking and stalling.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (calm || $urandom_range(0, 99) < 60) begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 5);
    end else begin
      out_stall  <= 1'b1;
      stall_hold <= pause_len() - 1;
    end
  end

  // Sample both channels at the edge; check results before noting the new byte
  // since a result never belongs to a byte taken at the same edge.
  always @(posedge clk) begin : monitor
    fcgirp_res_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.event_res       = fcgirp_event_t'(out_event_res);
        got.record_type     = out_record_type;
        got.request_id      = out_request_id;
        got.content_length  = out_content_length;
        got.padding_length  = out_padding_length;
        got.role            = out_role;
        got.keep_connection = out_keep_connection;
        got.name_length     = out_name_length;
        got.value_length    = out_value_length;
        got.payload_byte    = out_payload_byte;
        got.record_end      = out_record_end;
        sb.check_result(got);
      end
      if (in_valid && !in_stall) sb.note_byte(in_stream_byte);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  // Offer one byte, optionally after a gap, and hold it until taken.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 25) gap = pause_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  // Stop sending and wait until every expected result item has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Send header, rec_body as content and random padding; then clear rec_body.
  task automatic send_record(input logic [7:0] rtype, input logic [15:0] rid,
                             input logic [7:0] pad);
    logic [15:0] clen;
    clen = 16'(rec_body.size());
    send_byte(FCGI_VERSION);
    send_byte(rtype);
    send_byte(rid[15:8]);
    send_byte(rid[7:0]);
    send_byte(clen[15:8]);
    send_byte(clen[7:0]);
    send_byte(pad);
    send_byte(8'($urandom));
    foreach (rec_body[i]) send_byte(rec_body[i]);
    repeat (pad) send_byte(8'($urandom));
    rec_body.delete();
  endtask

  // Encode a pair length: short form when it fits and is not forced long.
  task automatic put_len(input logic [30:0] n, input bit wide);
    if (!wide && n < 128) begin
      rec_body.push_back(n[7:0]);
    end else begin
      rec_body.push_back({1'b1, n[30:24]});
      rec_body.push_back(n[23:16]);
      rec_body.push_back(n[15:8]);
      rec_body.push_back(n[7:0]);
    end
  endtask

  function automatic logic [30:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 31'($urandom_range(0, 6));
    if (r < 95) return 31'($urandom_range(7, 40));
    return 31'($urandom_range(41, 200));
  endfunction

  // Append well-formed name/value pairs with random content.
  task automatic put_pairs(input int unsigned npairs);
    logic [30:0] nl, vl;
    repeat (npairs) begin
      nl = pick_len();
      vl = pick_len();
      put_len(nl, $urandom_range(0, 3) == 0);
      put_len(vl, $urandom_range(0, 3) == 0);
      repeat (nl + vl) rec_body.push_back(8'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [7:0]  rtype, pad, bad;
    logic [15:0] rid;
    int unsigned r, target;

    calm = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty record ends in its own header
    send_record(REC_STDIN, 16'h0000, 8'd0);
    // begin request: responder with keep-connection, then all-ones role without it
    rec_body = '{8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_record(REC_BEGIN, 16'h0001, 8'd0);
    rec_body = '{8'hFF, 8'hFF, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_record(REC_BEGIN, 16'hFFFF, 8'd2);
    // short begin bodies: empty, one byte, two bytes
    send_record(REC_BEGIN, 16'h0002, 8'd3);
    rec_body = '{8'h00};
    send_record(REC_BEGIN, 16'h0003, 8'd0);
    rec_body = '{8'h00, 8'h01};
    send_record(REC_BEGIN, 16'h0004, 8'd1);
    // abort request content is skipped
    rec_body = '{8'h12, 8'h34, 8'h56};
    send_record(REC_ABORT, 16'h0005, 8'd0);
    // params: empty pair, short pair, long-form pair with empty value
    rec_body = '{8'h00, 8'h00, 8'h01, 8'h02, 8'h41, 8'h42, 8'h43,
                 8'h80, 8'h00, 8'h00, 8'h01, 8'h80, 8'h00, 8'h00, 8'h00, 8'h5A};
    send_record(REC_PARAMS, 16'h0006, 8'd0);
    // params: maximum name length overruns the record, rest is skipped
    rec_body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h11, 8'h22, 8'h33};
    send_record(REC_PARAMS, 16'h0007, 8'd4);
    // params: content ends inside a long value length
    rec_body = '{8'h03, 8'h80, 8'h12};
    send_record(REC_PARAMS, 16'h0008, 8'd0);
    // stdin extremes with maximum padding
    rec_body = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA};
    send_record(REC_STDIN, 16'h8000, 8'hFF);
    // unknown types, the last one with long content and maximum padding
    rec_body = '{8'h01, 8'h02, 8'h03};
    send_record(8'h00, 16'h0009, 8'd0);
    repeat (16'h0120) rec_body.push_back(8'($urandom));
    send_record(8'hFF, 16'hFFFF, 8'hFF);
    drain();

    // Random: mostly well-formed records, some broken bodies and unknown types
    target = sent_bytes + RANDOM_BYTES;
    while (sent_bytes < target) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      r   = $urandom_range(0, 99);
      pad = ($urandom_range(0, 49) == 0) ? 8'hFF :
            ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(1, 7));
      rid = 16'($urandom);
      if (r < 12) begin
        rtype = REC_BEGIN;
        if (r < 10) begin
          rec_body.push_back(($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom));
          rec_body.push_back(($urandom_range(0, 1) == 0) ? 8'h01 : 8'($urandom));
          repeat (6) rec_body.push_back(8'($urandom));
        end else begin
          repeat ($urandom_range(0, 10)) rec_body.push_back(8'($urandom));
        end
      end else if (r < 17) begin
        rtype = REC_ABORT;
        repeat ($urandom_range(0, 8)) rec_body.push_back(8'($urandom));
      end else if (r < 60) begin
        rtype = REC_PARAMS;
        put_pairs($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 20) begin
          case ($urandom_range(0, 2))
            0: begin
              // lengths that run past the end of the record
              put_len(31'($urandom), 1'b1);
              put_len(31'($urandom_range(0, 300)), $urandom_range(0, 1) == 1);
              repeat ($urandom_range(0, 4)) rec_body.push_back(8'($urandom));
            end
            1: begin
              // stop inside a length field
              if ($urandom_range(0, 1) == 0) begin
                rec_body.push_back(8'($urandom_range(0, 127)));
              end else begin
                rec_body.push_back(8'h80 | 8'($urandom));
                repeat ($urandom_range(0, 2)) rec_body.push_back(8'($urandom));
              end
            end
            default: repeat ($urandom_range(1, 12)) rec_body.push_back(8'($urandom));
          endcase
        end
      end else if (r < 82) begin
        rtype = REC_STDIN;
        repeat ($urandom_range(0, 24)) rec_body.push_back(8'($urandom));
      end else if (r < 90) begin
        do rtype = 8'($urandom);
        while (rtype == REC_BEGIN || rtype == REC_ABORT ||
               rtype == REC_PARAMS || rtype == REC_STDIN);
        repeat ($urandom_range(0, 16)) rec_body.push_back(8'($urandom));
      end else begin
        // noise content under a known type
        case ($urandom_range(0, 2))
          0:       rtype = REC_BEGIN;
          1:       rtype = REC_PARAMS;
          default: rtype = REC_STDIN;
        endcase
        repeat ($urandom_range(0, 20)) rec_body.push_back(8'($urandom));
      end
      send_record(rtype, rid, pad);
      if ($urandom_range(0, 29) == 0) drain();
    end

    // Bad version aborts the parser for good, so it closes the run;
    // the bytes after it must be dropped without results.
    calm = 1'b0;
    do bad = 8'($urandom);
    while (bad == FCGI_VERSION);
    send_byte(bad);
    repeat (6) send_byte(8'($urandom));

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
